// ===== rtl/windowed_pid_servo_with_friction_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PID_SERVO_WITH_FRICTION_MACROS_SVH
`define WINDOWED_PID_SERVO_WITH_FRICTION_MACROS_SVH
`ifndef SYNTHESIS
`define WPID_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define WPID_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define WPID_ASSERT_NOW(label, ante, cons)
`define WPID_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/wpid_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo controller package
// Widths, fixed-point constants, register map and shared types
// ----------------------------------------------------------------------------
package wpid_pkg;

	localparam int HISTORY_LEN = 10;
	localparam int ANG_W       = 20;
	localparam int ERR_W       = ANG_W + 1;
	localparam int SUM_W       = ERR_W + $clog2(HISTORY_LEN);
	localparam int GAIN_W      = 24;
	localparam int BORDER_W    = 19;
	localparam int OUT_W       = 24;
	localparam int FRAC_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int NSTG        = 6;

	localparam int P_W    = GAIN_W + 1 + ERR_W;
	localparam int I_W    = GAIN_W + 1 + SUM_W;
	localparam int D_W    = GAIN_W + 2 + ERR_W;
	localparam int ACC_W  = I_W + 2;
	localparam int VEL_W  = ACC_W - FRAC_W;
	localparam int MAG_W  = ANG_W;
	localparam int DYN_W  = GAIN_W + MAG_W;
	localparam int DYNT_W = DYN_W - FRAC_W + 1;
	localparam int FRIC_W = DYNT_W + 3;

	localparam logic signed [ERR_W-1:0] PI_Q16     = ERR_W'(205887);
	localparam logic signed [ERR_W-1:0] TWO_PI_Q16 = ERR_W'(411775);
	localparam int HALF_LSB = 2 ** (FRAC_W - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_P_GAIN,
		CFG_I_GAIN,
		CFG_D_GAIN,
		CFG_MAX_VELOCITY,
		CFG_STATIC_FRICTION,
		CFG_STATIC_BORDER,
		CFG_DYN_FRICTION_GAIN,
		CFG_FRICTION_OFFSET
	} cfg_idx_t;

	typedef struct packed {
		logic        [GAIN_W-1:0]   p_gain;
		logic        [GAIN_W-1:0]   i_gain;
		logic        [GAIN_W-1:0]   d_gain;
		logic signed [GAIN_W-1:0]   max_velocity;
		logic        [GAIN_W-1:0]   static_friction;
		logic        [BORDER_W-1:0] static_border;
		logic        [GAIN_W-1:0]   dynamic_friction_gain;
		logic signed [GAIN_W-1:0]   friction_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		p_gain:                GAIN_W'(1310720),
		i_gain:                '0,
		d_gain:                '0,
		max_velocity:          GAIN_W'(229376),
		static_friction:       GAIN_W'(66),
		static_border:         BORDER_W'(66),
		dynamic_friction_gain: GAIN_W'(1048576),
		friction_offset:       '0
	};

	typedef struct packed {
		logic                    vld;
		logic signed [ERR_W-1:0] err;
	} err_cell_t;

	typedef struct packed {
		logic empty;
		logic full;
	} win_stat_t;

endpackage

// ===== rtl/wpid_ifs.sv =====
// ----------------------------------------------------------------------------
// Servo controller channels
// Valid/ready channels for the sample word and the command word
// ----------------------------------------------------------------------------
interface wpid_in_if;
	import wpid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ANG_W-1:0] measured_angle;
	logic signed [ANG_W-1:0] target_angle;

	modport source (output valid, output measured_angle, output target_angle, input ready);
	modport sink (input valid, input measured_angle, input target_angle, output ready);
endinterface

interface wpid_out_if;
	import wpid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] velocity_command;
	logic        [OUT_W-1:0] friction_value;

	modport source (output valid, output velocity_command, output friction_value, input ready);
	modport sink (input valid, input velocity_command, input friction_value, output ready);
endinterface

// ===== rtl/wpid_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Gains, clamp and friction settings written through a plain write port
// ----------------------------------------------------------------------------
module wpid_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                we,
	input  logic [wpid_pkg::CFG_IDX_W-1:0]      index,
	input  logic [wpid_pkg::GAIN_W-1:0]         data,
	output wpid_pkg::cfg_t                      cfg
);
	import wpid_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (we) begin
			case (cfg_idx_t'(index))
				CFG_P_GAIN:            cfg_q.p_gain <= data;
				CFG_I_GAIN:            cfg_q.i_gain <= data;
				CFG_D_GAIN:            cfg_q.d_gain <= data;
				CFG_MAX_VELOCITY:      cfg_q.max_velocity <= data;
				CFG_STATIC_FRICTION:   cfg_q.static_friction <= data;
				CFG_STATIC_BORDER:     cfg_q.static_border <= data[BORDER_W-1:0];
				CFG_DYN_FRICTION_GAIN: cfg_q.dynamic_friction_gain <= data;
				CFG_FRICTION_OFFSET:   cfg_q.friction_offset <= data;
				default:               cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/wpid_cell.sv =====
// ----------------------------------------------------------------------------
// Error window cell
// One slot of the error history, passes its entry on at every shift
// ----------------------------------------------------------------------------
module wpid_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  wpid_pkg::err_cell_t d,
	output wpid_pkg::err_cell_t q
);
	import wpid_pkg::*;

	logic                    vld_q;
	logic signed [ERR_W-1:0] err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			err_q <= d.err;
		end
	end

	assign q = '{vld: vld_q, err: err_q};

endmodule

// ===== rtl/wpid_window.sv =====
// ----------------------------------------------------------------------------
// Sliding error window
// Row of history cells with a running sum of the valid entries
// ----------------------------------------------------------------------------
module wpid_window (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               shift,
	input  logic signed [wpid_pkg::ERR_W-1:0]  err,
	output logic signed [wpid_pkg::SUM_W-1:0]  sum_nxt,
	output logic signed [wpid_pkg::SUM_W-1:0]  sum,
	output wpid_pkg::win_stat_t                stat
);
	import wpid_pkg::*;

	err_cell_t               chain [0:HISTORY_LEN];
	err_cell_t               oldest;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] drop;

	assign chain[0] = '{vld: 1'b1, err: err};

	for (genvar k = 0; k < HISTORY_LEN; k++) begin : g_cell
		wpid_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (chain[k]),
			.q      (chain[k+1])
		);
	end

	assign oldest = chain[HISTORY_LEN];

	// oldest entry leaves the sum once the window is full
	always_comb begin
		drop    = oldest.vld ? SUM_W'(oldest.err) : '0;
		sum_nxt = sum_q + SUM_W'(err) - drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (shift) begin
			sum_q <= sum_nxt;
		end
	end

	assign sum  = sum_q;
	assign stat = '{empty: !chain[1].vld, full: oldest.vld};

endmodule

// ===== rtl/windowed_pid_servo_with_friction.sv =====
// ----------------------------------------------------------------------------
// Windowed PID servo with friction
// Wraps the target, runs a PID with a sliding-window integral and derives
// a friction value from the position change per tick
// ----------------------------------------------------------------------------
//  channel   dir  word                                   handshake
//  sample    in   measured_angle, target_angle           valid/ready
//  command   out  velocity_command, friction_value       valid/ready
//  cfg       in   cfg_index, cfg_data                    cfg_we, no wait
//
//  six-stage pipeline, one word per cycle unless a stage holds
//  the window is a row of history cells shifted once per word in stage three
//  a stage holds while the one after it is full and stalled; ready drops
//  only when every stage is full and the command word is not taken
//  reset clears the window, the running sum and the stage valid bits
// ----------------------------------------------------------------------------
`include "windowed_pid_servo_with_friction_macros.svh"

module windowed_pid_servo_with_friction (
	input  logic                               clk,
	input  logic                               arst_n,
	wpid_in_if.sink                            sample,
	wpid_out_if.source                         command,
	input  logic                               cfg_we,
	input  logic [wpid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wpid_pkg::GAIN_W-1:0]        cfg_data
);
	import wpid_pkg::*;

	localparam logic signed [VEL_W-1:0]  VEL_MAX  = VEL_W'(2 ** (OUT_W - 1) - 1);
	localparam logic signed [VEL_W-1:0]  VEL_MIN  = -VEL_W'(2 ** (OUT_W - 1));
	localparam logic signed [FRIC_W-1:0] FRIC_MAX = FRIC_W'(2 ** OUT_W - 1);

	cfg_t      cfg;
	win_stat_t win_stat;

	logic [NSTG:1] stage_vld_q;
	logic [NSTG:1] stage_en;

	// stage 1
	logic signed [ANG_W-1:0] meas_s1;
	logic signed [ANG_W-1:0] tgt_s1;
	// stage 2
	logic signed [ERR_W-1:0] e_s2;
	logic signed [ERR_W-1:0] dpos_s2;
	// stage 3
	logic signed [ERR_W-1:0] e_s3;
	logic signed [SUM_W-1:0] sum_s3;
	logic signed [ERR_W:0]   derr_s3;
	logic        [MAG_W-1:0] adpos_s3;
	// stage 4
	logic signed [P_W-1:0]   prod_p_s4;
	logic signed [I_W-1:0]   prod_i_s4;
	logic signed [D_W-1:0]   prod_d_s4;
	logic        [DYN_W-1:0] prod_f_s4;
	logic                    hit_s4;
	// stage 5
	logic signed [VEL_W-1:0]  vel_s5;
	logic signed [FRIC_W-1:0] fric_s5;
	// stage 6
	logic signed [OUT_W-1:0] vel_s6;
	logic        [OUT_W-1:0] fric_s6;

	logic signed [ERR_W-1:0] prev_ang_q;
	logic signed [ERR_W-1:0] prev_err_q;

	logic signed [ERR_W-1:0]  tgt_x;
	logic signed [ERR_W-1:0]  tgt_w;
	logic signed [ERR_W-1:0]  meas_x;
	logic signed [ERR_W-1:0]  dpos_mag;
	logic signed [SUM_W-1:0]  win_sum_nxt;
	logic signed [SUM_W-1:0]  win_sum;
	logic signed [ACC_W-1:0]  acc;
	logic        [DYN_W:0]    dyn_rnd;
	logic signed [FRIC_W-1:0] fric_sum;
	logic signed [VEL_W-1:0]  mv_x;
	logic signed [VEL_W-1:0]  vel_c;
	logic        [OUT_W-1:0]  fric_c;
	logic                     win_shift;

	wpid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// stage enables
	always_comb begin
		stage_en[NSTG] = !stage_vld_q[NSTG] || command.ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[1]) begin
				stage_vld_q[1] <= sample.valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	assign sample.ready = stage_en[1];

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			meas_s1 <= sample.measured_angle;
			tgt_s1  <= sample.target_angle;
		end
	end

	// stage 2: wrap target, error and position change
	always_comb begin
		tgt_x  = ERR_W'(tgt_s1);
		meas_x = ERR_W'(meas_s1);
		if (tgt_x > PI_Q16) begin
			tgt_w = tgt_x - TWO_PI_Q16;
		end else if (tgt_x < -PI_Q16) begin
			tgt_w = tgt_x + TWO_PI_Q16;
		end else begin
			tgt_w = tgt_x;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			e_s2    <= tgt_w - meas_x;
			dpos_s2 <= meas_x - prev_ang_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ang_q <= '0;
		end else if (stage_vld_q[1] && stage_en[2]) begin
			prev_ang_q <= meas_x;
		end
	end

	// stage 3: window, derivative, magnitude
	assign win_shift = stage_vld_q[2] && stage_en[3];

	wpid_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (win_shift),
		.err     (e_s2),
		.sum_nxt (win_sum_nxt),
		.sum     (win_sum),
		.stat    (win_stat)
	);

	assign dpos_mag = dpos_s2[ERR_W-1] ? -dpos_s2 : dpos_s2;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			e_s3     <= e_s2;
			sum_s3   <= win_sum_nxt;
			derr_s3  <= (ERR_W+1)'(e_s2) - (ERR_W+1)'(prev_err_q);
			adpos_s3 <= dpos_mag[MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (win_shift) begin
			prev_err_q <= e_s2;
		end
	end

	// stage 4: products
	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			prod_p_s4 <= signed'({1'b0, cfg.p_gain}) * e_s3;
			prod_i_s4 <= signed'({1'b0, cfg.i_gain}) * sum_s3;
			prod_d_s4 <= signed'({1'b0, cfg.d_gain}) * derr_s3;
			prod_f_s4 <= cfg.dynamic_friction_gain * adpos_s3;
			hit_s4    <= adpos_s3 < MAG_W'(cfg.static_border);
		end
	end

	// stage 5: accumulate and round
	always_comb begin
		acc = ACC_W'(prod_p_s4) + ACC_W'(prod_i_s4) + ACC_W'(prod_d_s4)
			+ ACC_W'(HALF_LSB);
		dyn_rnd  = {1'b0, prod_f_s4} + (DYN_W+1)'(HALF_LSB);
		fric_sum = signed'(FRIC_W'(hit_s4 ? cfg.static_friction : '0))
			+ signed'(FRIC_W'(dyn_rnd[DYN_W:FRAC_W]))
			+ FRIC_W'(cfg.friction_offset);
	end

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			vel_s5  <= acc[ACC_W-1:FRAC_W];
			fric_s5 <= fric_sum;
		end
	end

	// stage 6: clamp, floor, saturate
	always_comb begin
		mv_x  = VEL_W'(cfg.max_velocity);
		vel_c = vel_s5;
		if (!mv_x[VEL_W-1]) begin
			if (vel_s5 > 0) begin
				if (vel_s5 > mv_x) begin
					vel_c = mv_x;
				end
			end else if (vel_s5 < -mv_x) begin
				vel_c = -mv_x;
			end
		end
		if (vel_c > VEL_MAX) begin
			vel_c = VEL_MAX;
		end else if (vel_c < VEL_MIN) begin
			vel_c = VEL_MIN;
		end

		if (cfg.static_friction == '0 && cfg.dynamic_friction_gain == '0) begin
			fric_c = '0;
		end else if (fric_s5[FRIC_W-1]) begin
			fric_c = '0;
		end else if (fric_s5 > FRIC_MAX) begin
			fric_c = '1;
		end else begin
			fric_c = fric_s5[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			vel_s6  <= vel_c[OUT_W-1:0];
			fric_s6 <= fric_c;
		end
	end

	assign command.valid            = stage_vld_q[NSTG];
	assign command.velocity_command = vel_s6;
	assign command.friction_value   = fric_s6;

	`WPID_ASSERT_NOW(a_ready_low_full, !sample.ready, (&stage_vld_q) && !command.ready)
	`WPID_ASSERT_NOW(a_empty_sum_zero, win_stat.empty, win_sum == '0)
	`WPID_ASSERT_NOW(a_full_not_empty, win_stat.full, !win_stat.empty)
	`WPID_ASSERT_NEXT(a_stage_hold, stage_vld_q[1] && !stage_en[2], stage_vld_q[1] && $stable(meas_s1))

endmodule
